### hdl/rdc_pkg.sv
`default_nettype none
// ============================================================================
// rdc_pkg: shared types, constants and functions of the radix digit converter
// Holds the item and result beat layouts, radix clamping, the chunked
// divide step used by the digit loop and the digit-to-ASCII mapping.
// ============================================================================
package rdc_pkg;

    // Field widths
    localparam int VALUE_W  = 31;
    localparam int RADIX_W  = 5;
    localparam int CHAR_W   = 7;
    localparam int DIGIT_W  = 4;

    // Dividend bits consumed per divide cycle
    localparam int CHUNK_W  = 8;

    // Parameter defaults
    localparam int VALUE_BITS_DEF  = 31;
    localparam int STACK_DEPTH_DEF = 32;

    // Radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    // ASCII mapping
    localparam logic [CHAR_W-1:0]  ZERO_CHAR      = 7'd48;
    localparam logic [CHAR_W-1:0]  LETTER_BASE    = 7'd65;
    localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 4'd10;

    // Queue depths
    localparam int REQ_DEPTH = 2;
    localparam int OUT_DEPTH = 4;
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } out_t;

    // Front-to-back request: head of the request queue
    typedef struct packed {
        logic vld;
        in_t  item;
    } rdc_req_t;

    // Back-to-result-queue beat
    typedef struct packed {
        logic vld;
        out_t data;
    } rdc_beat_t;

    // Clamp a radix into 2..16
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    // Divide {rem, chunk} by radix; returns {quotient bits, new remainder}.
    // rem is below radix, so each partial value fits in five bits.
    function automatic logic [CHUNK_W+DIGIT_W-1:0] div_chunk(
        input logic [DIGIT_W-1:0] rem,
        input logic [CHUNK_W-1:0] chunk,
        input logic [RADIX_W-1:0] radix
    );
        logic [RADIX_W-1:0] part;
        logic [CHUNK_W-1:0] q;
        part = {1'b0, rem};
        q    = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            part = {part[DIGIT_W-1:0], chunk[i]};
            if (part >= radix)
            begin
                part = part - radix;
                q[i] = 1'b1;
            end
        end
        return {q, part[DIGIT_W-1:0]};
    endfunction

    // Map a digit to '0'..'9' or 'A'..'F'
    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DECIMAL_DIGITS)
        begin
            c = LETTER_BASE + CHAR_W'(d - DECIMAL_DIGITS);
        end
        else
        begin
            c = ZERO_CHAR + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hdl/rdc_front.sv
`default_nettype none
// ============================================================================
// rdc_front: input side of the converter
// Accepts item beats, masks the value and clamps the radix, and holds them
// in a short request queue until the digit engine takes them.
// ============================================================================
module rdc_front #(
    parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rdc_pkg::in_t    item,
    output logic                 full,
    output rdc_pkg::rdc_req_t    req,
    input  wire logic            take
);

    localparam int EFF_W = (VALUE_BITS < rdc_pkg::VALUE_W) ? VALUE_BITS : rdc_pkg::VALUE_W;
    localparam logic [rdc_pkg::VALUE_W-1:0] VALUE_MASK =
        {rdc_pkg::VALUE_W{1'b1}} >> (rdc_pkg::VALUE_W - EFF_W);
    localparam int PTR_W = $clog2(rdc_pkg::REQ_DEPTH);
    localparam int CNT_W = $clog2(rdc_pkg::REQ_DEPTH + 1);

    rdc_pkg::in_t       q_reg [rdc_pkg::REQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;
    rdc_pkg::in_t       clean;

    // Classify the incoming beat
    always_comb
    begin
        clean.value = item.value & VALUE_MASK;
        clean.radix = rdc_pkg::clamp_radix(item.radix);
    end

    assign full    = (cnt_reg == CNT_W'(rdc_pkg::REQ_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = take && (cnt_reg != '0);

    assign req.vld  = (cnt_reg != '0);
    assign req.item = q_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(rdc_pkg::REQ_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(rdc_pkg::REQ_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued items
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= clean;
        end
    end

endmodule
`default_nettype wire

### hdl/rdc_back.sv
`default_nettype none
// ============================================================================
// rdc_back: digit engine of the converter
// Divides the value by the radix one chunk per cycle, pushes each remainder
// on the digit stack, then pops the stack most significant digit first and
// sends ASCII beats to the result queue under a credit check.
// ============================================================================
module rdc_back #(
    parameter int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF,
    parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rdc_pkg::rdc_req_t           req,
    output logic                             take,
    input  wire logic [rdc_pkg::OCNT_W-1:0]  out_cnt,
    output rdc_pkg::rdc_beat_t               beat
);

    localparam int EFF_W  = (VALUE_BITS < rdc_pkg::VALUE_W) ? VALUE_BITS : rdc_pkg::VALUE_W;
    localparam int NCHUNK = (EFF_W + rdc_pkg::CHUNK_W - 1) / rdc_pkg::CHUNK_W;
    localparam int QW     = NCHUNK * rdc_pkg::CHUNK_W;
    localparam int SW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int AW     = $clog2(STACK_DEPTH);
    localparam int CW     = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [QW-1:0]                  quo_reg, quo_next;
    logic [rdc_pkg::DIGIT_W-1:0]    rem_reg, rem_next;
    logic [rdc_pkg::RADIX_W-1:0]    radix_reg, radix_next;
    logic [SW-1:0]                  step_reg, step_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic                           rd_vld_reg;
    logic                           rd_last_reg;
    logic [rdc_pkg::DIGIT_W-1:0]    rd_data_reg;
    logic [rdc_pkg::DIGIT_W-1:0]    stack_mem [STACK_DEPTH];

    logic [rdc_pkg::CHUNK_W+rdc_pkg::DIGIT_W-1:0] div_res;
    logic [rdc_pkg::CHUNK_W-1:0]    chunk_q;
    logic [rdc_pkg::DIGIT_W-1:0]    chunk_r;
    logic [QW-1:0]                  quo_shift;
    logic                           last_step;
    logic                           wr_en;
    logic                           issue;
    logic [CW-1:0]                  rd_ptr;

    // Divide one chunk of the running quotient
    assign div_res   = rdc_pkg::div_chunk(rem_reg, quo_reg[QW-1 -: rdc_pkg::CHUNK_W], radix_reg);
    assign chunk_q   = div_res[rdc_pkg::CHUNK_W+rdc_pkg::DIGIT_W-1 -: rdc_pkg::CHUNK_W];
    assign chunk_r   = div_res[rdc_pkg::DIGIT_W-1:0];
    assign quo_shift = (quo_reg << rdc_pkg::CHUNK_W) | QW'(chunk_q);
    assign last_step = (step_reg == SW'(NCHUNK - 1));

    // Pop the stack when the result queue has room for the read in flight
    assign rd_ptr = cnt_reg - 1'b1;
    assign issue  = (state_reg == S_EMIT) && (cnt_reg != '0) &&
                    ((int'(out_cnt) + int'(rd_vld_reg)) < rdc_pkg::OUT_DEPTH);
    assign wr_en  = (state_reg == S_DIV) && last_step;
    assign take   = (state_reg == S_IDLE) && req.vld;

    // Sequence division and emission
    always_comb
    begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.vld)
                begin
                    quo_next   = QW'(req.item.value[EFF_W-1:0]);
                    radix_next = req.item.radix;
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                quo_next = quo_shift;
                rem_next = chunk_r;
                if (last_step)
                begin
                    rem_next  = '0;
                    step_next = '0;
                    cnt_next  = cnt_reg + 1'b1;
                    if ((quo_shift == '0) || (cnt_reg == CW'(STACK_DEPTH - 1)))
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= issue;
        end
    end

    // Hold datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
    end

    // Digit stack: push during division, registered pop during emission
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[cnt_reg[AW-1:0]] <= chunk_r;
        end
        if (issue)
        begin
            rd_data_reg <= stack_mem[rd_ptr[AW-1:0]];
            rd_last_reg <= (cnt_reg == CW'(1));
        end
    end

    assign beat.vld             = rd_vld_reg;
    assign beat.data.digit_char = rdc_pkg::to_ascii(rd_data_reg);
    assign beat.data.last       = rd_last_reg;

endmodule
`default_nettype wire

### hdl/rdc_out_q.sv
`default_nettype none
// ============================================================================
// rdc_out_q: result queue of the converter
// Buffers ASCII digit beats from the digit engine and presents the oldest
// one to the consumer; reports its occupancy back for credit.
// ============================================================================
module rdc_out_q (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rdc_pkg::rdc_beat_t          beat,
    output logic [rdc_pkg::OCNT_W-1:0]       out_cnt,
    input  wire logic                        pop,
    output logic                             empty,
    output rdc_pkg::out_t                    result
);

    localparam int PTR_W = $clog2(rdc_pkg::OUT_DEPTH);
    localparam int CNT_W = rdc_pkg::OCNT_W;

    rdc_pkg::out_t      q_reg [rdc_pkg::OUT_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_pop;

    assign empty   = (cnt_reg == '0);
    assign do_pop  = pop && !empty;
    assign out_cnt = cnt_reg;
    assign result  = q_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (beat.vld)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(rdc_pkg::OUT_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(rdc_pkg::OUT_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (beat.vld && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!beat.vld && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued digits
    always_ff @(posedge clk)
    begin
        if (beat.vld)
        begin
            q_reg[wr_ptr_reg] <= beat.data;
        end
    end

endmodule
`default_nettype wire

### hdl/radix_digit_converter.sv
`default_nettype none
// Flow: an item is registered in the request queue until the digit engine takes it,
// then the chunked divider works through the value in 8-bit chunks for each digit,
// then the stack is popped through a registered read while the result queue has room.
// The engine takes a new item only when idle, once every digit of the last one is popped;
// meanwhile the request queue holds up to two waiting items.
// Reset clears all control state; the digit stack needs no clearing pass.
// ============================================================================
// radix_digit_converter: integer to ASCII digits in a radix from 2 to 16
// Front queue takes items, the digit engine divides and unstacks digits,
// and a result queue hands ASCII beats out, least significant flagged last.
// ============================================================================
module radix_digit_converter #(
    parameter int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF,
    parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire rdc_pkg::in_t  item,
    output logic               full,
    output logic               empty,
    input  wire logic          pop,
    output rdc_pkg::out_t      result
);

    rdc_pkg::rdc_req_t              req;
    logic                           take;
    rdc_pkg::rdc_beat_t             beat;
    logic [rdc_pkg::OCNT_W-1:0]     out_cnt;

    // Accept and classify items
    rdc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .req   (req),
        .take  (take)
    );

    // Divide and unstack digits
    rdc_back #(
        .VALUE_BITS  (VALUE_BITS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .take    (take),
        .out_cnt (out_cnt),
        .beat    (beat)
    );

    // Buffer result beats
    rdc_out_q u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (beat),
        .out_cnt (out_cnt),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule
`default_nettype wire

### tb/radix_digit_converter_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// radix_digit_converter_tb: self-checking bench for the radix digit converter
// Sends integer and radix beats through the push side. It predicts the ASCII
// digit beats of each value, most significant first with the last one
// flagged, and checks every popped beat against the oldest prediction. Both
// sides idle at random in phases.
// ============================================================================
module radix_digit_converter_tb;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 5000;
    localparam logic [rdc_pkg::VALUE_W-1:0] VALUE_ALL_ONES = '1;

    logic          clk    = 1'b0;
    logic          rst_n  = 1'b0;
    logic          push   = 1'b0;
    rdc_pkg::in_t  item   = '0;
    logic          pop    = 1'b0;
    logic          full;
    logic          empty;
    rdc_pkg::out_t result;

    // Digit beats still owed by the block, oldest first
    rdc_pkg::out_t pending_digits[$];
    int   errors         = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles   = 0;

    radix_digit_converter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Predict the digit beats of one value and queue them
    function automatic void queue_digits_of(input rdc_pkg::in_t beat);
        logic [rdc_pkg::VALUE_W-1:0] quotient;
        logic [rdc_pkg::RADIX_W-1:0] base;
        logic [rdc_pkg::DIGIT_W-1:0] stack[rdc_pkg::STACK_DEPTH_DEF];
        int                          depth;
        rdc_pkg::out_t               digit_beat;
        base = beat.radix;
        if (base < rdc_pkg::RADIX_MIN)
        begin
            base = rdc_pkg::RADIX_MIN;
        end
        else if (base > rdc_pkg::RADIX_MAX)
        begin
            base = rdc_pkg::RADIX_MAX;
        end
        quotient = beat.value;
        depth    = 0;
        if (quotient == '0)
        begin
            stack[0] = '0;
            depth    = 1;
        end
        while (quotient != '0 && depth < rdc_pkg::STACK_DEPTH_DEF)
        begin
            stack[depth] = rdc_pkg::DIGIT_W'(quotient % base);
            quotient     = quotient / base;
            depth++;
        end
        for (int i = depth - 1; i >= 0; i--)
        begin
            if (stack[i] >= rdc_pkg::DECIMAL_DIGITS)
                digit_beat.digit_char = rdc_pkg::LETTER_BASE
                    + rdc_pkg::CHAR_W'(stack[i] - rdc_pkg::DECIMAL_DIGITS);
            else
                digit_beat.digit_char = rdc_pkg::ZERO_CHAR + rdc_pkg::CHAR_W'(stack[i]);
            digit_beat.last = (i == 0);
            pending_digits.push_back(digit_beat);
        end
    endfunction

    // Mostly short values, so runs stay fast; some full width and the extremes
    function automatic logic [rdc_pkg::VALUE_W-1:0] random_value();
        int                          width;
        int                          pick;
        logic [rdc_pkg::VALUE_W-1:0] mask;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return '0;
        if (pick < 8)
            return VALUE_ALL_ONES;
        if (pick < 70)
            width = $urandom_range(1, 12);
        else
            width = $urandom_range(13, rdc_pkg::VALUE_W);
        mask = VALUE_ALL_ONES >> (rdc_pkg::VALUE_W - width);
        return rdc_pkg::VALUE_W'($urandom) & mask;
    endfunction

    // Mostly legal radixes, the rest anywhere in the field to hit clamping
    function automatic logic [rdc_pkg::RADIX_W-1:0] random_radix();
        if ($urandom_range(0, 99) < 85)
            return rdc_pkg::RADIX_W'($urandom_range(rdc_pkg::RADIX_MIN, rdc_pkg::RADIX_MAX));
        return rdc_pkg::RADIX_W'($urandom_range(0, (1 << rdc_pkg::RADIX_W) - 1));
    endfunction

    // Send one beat, idling at random first; push stays high after acceptance
    task automatic send_item(input rdc_pkg::in_t beat);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= beat;
        @(posedge clk);
        while (full)
            @(posedge clk);
        queue_digits_of(beat);
    endtask

    task automatic send_pair(input logic [rdc_pkg::VALUE_W-1:0] value,
                             input logic [rdc_pkg::RADIX_W-1:0] radix);
        rdc_pkg::in_t beat;
        beat.value = value;
        beat.radix = radix;
        send_item(beat);
    endtask

    // Zero, the value extremes, both clamping directions and every letter
    task automatic test_special_values();
        send_pair('0, rdc_pkg::RADIX_W'(10));
        send_pair('0, '0);
        send_pair(VALUE_ALL_ONES, rdc_pkg::RADIX_MIN);
        send_pair(VALUE_ALL_ONES, rdc_pkg::RADIX_MAX);
        send_pair(VALUE_ALL_ONES, '1);
        send_pair(rdc_pkg::VALUE_W'(1), rdc_pkg::RADIX_W'(1));
        send_pair(rdc_pkg::VALUE_W'(17), rdc_pkg::RADIX_W'(17));
        send_pair(rdc_pkg::VALUE_W'(32'h0FED_CBA9), rdc_pkg::RADIX_MAX);
    endtask

    // Each radix with a value whose digits are all the top digit
    task automatic test_every_radix();
        for (int r = rdc_pkg::RADIX_MIN; r <= rdc_pkg::RADIX_MAX; r++)
            send_pair(rdc_pkg::VALUE_W'(r * r * r - 1), rdc_pkg::RADIX_W'(r));
    endtask

    task automatic test_random_mix(input int count, input int s_pct, input int r_pct);
        rdc_pkg::in_t beat;
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        repeat (count)
        begin
            beat.value = random_value();
            beat.radix = random_radix();
            send_item(beat);
        end
    endtask

    // Drive pop at the falling edge, stalling at the phase's rate
    always @(negedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check each popped beat against the oldest prediction
    always @(posedge clk)
    begin
        rdc_pkg::out_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_digits.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat: expected none, actual char=%0d last=%0b",
                         $time, result.digit_char, result.last);
            end
            else
            begin
                want = pending_digits.pop_front();
                if (result.digit_char !== want.digit_char)
                begin
                    errors++;
                    $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                             $time, want.digit_char, result.digit_char);
                end
                if (result.last !== want.last)
                begin
                    errors++;
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, result.last);
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct  = 10;
        recv_stall_pct = 83;
        test_special_values();
        test_every_radix();
        test_random_mix(66, 10, 83);
        test_random_mix(66, 83, 10);
        test_random_mix(65, 0, 0);

        @(negedge clk);
        push <= 1'b0;

        // Drain outstanding beats, then hold for stray ones
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
